/* design/spmq_pkg.sv */
`timescale 1ns / 1ps

package spmq_pkg;

	localparam int FUNC_W      = 2;
	localparam int QID_W       = 4;
	localparam int QID_N       = 2 ** QID_W;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = 11;
	localparam int STAT_W      = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (STAT_W + DATA_W + CNT_W);

	localparam int NUM_QUEUES_DEF = 16;
	localparam int POOL_DEPTH_DEF = 1024;

	// per-queue entry cap, also the reset value of the limit register
	localparam logic [CNT_W-1:0] QUEUE_CAP = 11'd1024;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH_TAIL = 2'd0,
		FUNC_PUSH_HEAD = 2'd1,
		FUNC_POP_HEAD  = 2'd2,
		FUNC_SIZE      = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_LIMIT     = 2'd1,
		STAT_EXHAUSTED = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

endpackage

/* design/spmq_qtable.sv */
`timescale 1ns / 1ps

module spmq_qtable #(
	parameter int NUM_QUEUES = spmq_pkg::NUM_QUEUES_DEF,
	parameter int PW         = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [$clog2(NUM_QUEUES)-1:0]   rd_idx,
	output logic [PW-1:0]                   rd_head,
	output logic [PW-1:0]                   rd_tail,
	output logic [spmq_pkg::CNT_W-1:0]      rd_size,
	input  logic                            wr_en,
	input  logic [$clog2(NUM_QUEUES)-1:0]   wr_idx,
	input  logic [PW-1:0]                   wr_head,
	input  logic [PW-1:0]                   wr_tail,
	input  logic [spmq_pkg::CNT_W-1:0]      wr_size
);

	localparam int WW = 2 * PW + spmq_pkg::CNT_W;

	logic [WW-1:0] mem [NUM_QUEUES];
	logic          vld_q [NUM_QUEUES];
	logic [WW-1:0] wr_word;
	logic [WW-1:0] rd_word_q;
	logic          rd_vld_q;

	assign wr_word = {wr_head, wr_tail, wr_size};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_word;
		end
	end

	// write-through on same-index read keeps back-to-back ops coherent
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_idx == rd_idx)) begin
				rd_word_q <= wr_word;
			end else begin
				rd_word_q <= mem[rd_idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				vld_q[i] <= 1'b0;
			end
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= (wr_en && (wr_idx == rd_idx)) || vld_q[rd_idx];
			end
		end
	end

	// unwritten queues read as empty with zero pointers
	assign {rd_head, rd_tail, rd_size} = rd_vld_q ? rd_word_q : '0;

endmodule

/* design/spmq_slots.sv */
`timescale 1ns / 1ps

module spmq_slots #(
	parameter int POOL_DEPTH = spmq_pkg::POOL_DEPTH_DEF,
	parameter int PW         = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [PW-1:0]               rd_data_addr,
	input  logic [PW-1:0]               rd_next_addr,
	output logic [spmq_pkg::DATA_W-1:0] rd_data,
	output logic [PW-1:0]               rd_next,
	input  logic                        wr_data_en,
	input  logic [PW-1:0]               wr_data_addr,
	input  logic [spmq_pkg::DATA_W-1:0] wr_data,
	input  logic                        wr_next_en,
	input  logic [PW-1:0]               wr_next_addr,
	input  logic [PW-1:0]               wr_next,
	input  logic                        take_en,
	input  logic [PW-1:0]               take_addr
);

	localparam int MW = $clog2(POOL_DEPTH + 1);

	logic [spmq_pkg::DATA_W-1:0] data_mem [POOL_DEPTH];
	logic [PW-1:0]               next_mem [POOL_DEPTH];
	logic [spmq_pkg::DATA_W-1:0] data_rd_q;
	logic [PW-1:0]               next_rd_q;
	logic [PW-1:0]               next_addr_q;
	logic [MW-1:0]               mark_q;
	logic [PW-1:0]               seq_next;

	always_ff @(posedge clk) begin
		if (wr_data_en) begin
			data_mem[wr_data_addr] <= wr_data;
		end
		if (rd_en) begin
			data_rd_q <= data_mem[rd_data_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_next_en) begin
			next_mem[wr_next_addr] <= wr_next;
		end
		if (rd_en) begin
			next_rd_q   <= next_mem[rd_next_addr];
			next_addr_q <= rd_next_addr;
		end
	end

	// slots at or above the mark were never handed out: their link is the
	// power-up chain to the following slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= '0;
		end else if (take_en && (MW'(take_addr) == mark_q)) begin
			mark_q <= mark_q + 1'b1;
		end
	end

	assign seq_next = (next_addr_q == PW'(POOL_DEPTH - 1)) ? '0 : next_addr_q + 1'b1;
	assign rd_next  = (MW'(next_addr_q) < mark_q) ? next_rd_q : seq_next;
	assign rd_data  = data_rd_q;

endmodule

/* design/shared_pool_multi_queue_unit.sv */
`timescale 1ns / 1ps

// Shared-pool multi-queue: NUM_QUEUES linked-list FIFOs over one pool of
// POOL_DEPTH slots with a free list. Each beat on s_axis is one operation
// (push tail, push head, pop head, size query) and yields exactly one beat on
// m_axis with status, popped word and the queue's new count. The queue
// pointer table is read at the accepting edge, then the slot link and data
// stores are read with the pointer it returned, and then the update and the
// result are written. A new operation is not accepted while one is in the
// first stage, nor while the second stage holds one that is not completing.
// While a result waits on m_axis, the operation behind it holds in the second
// stage and the input stalls; one more beat is still accepted before that. No
// clearing pass is needed after reset; the block is ready at once.
module shared_pool_multi_queue_unit #(
	parameter int NUM_QUEUES = spmq_pkg::NUM_QUEUES_DEF,
	parameter int POOL_DEPTH = spmq_pkg::POOL_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [spmq_pkg::CNT_W-1:0]        cfg_wdata,     // queue_limit
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [spmq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // func, queue_id, payload
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [spmq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // status, data_out, queue_count
);

	localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW     = $clog2(POOL_DEPTH);
	localparam int FCW    = $clog2(POOL_DEPTH + 1);
	localparam int CNT_W  = spmq_pkg::CNT_W;
	localparam int DATA_W = spmq_pkg::DATA_W;
	localparam int FUNC_W = spmq_pkg::FUNC_W;
	localparam int QID_W  = spmq_pkg::QID_W;

	// queue_id folded onto the queue count
	logic [QW-1:0] qmap [spmq_pkg::QID_N];
	for (genvar g = 0; g < spmq_pkg::QID_N; g++) begin : g_qmap
		assign qmap[g] = QW'(g % NUM_QUEUES);
	end

	spmq_pkg::func_t         func_in;
	logic [QW-1:0]           q_in;
	logic                    in_beat;

	logic                    valid_s1;
	spmq_pkg::func_t         func_s1;
	logic [QW-1:0]           q_s1;
	logic [DATA_W-1:0]       payload_s1;

	logic                    valid_s2;
	spmq_pkg::func_t         func_s2;
	logic [QW-1:0]           q_s2;
	logic [DATA_W-1:0]       payload_s2;
	logic [PW-1:0]           head_s2;
	logic [PW-1:0]           tail_s2;
	logic [CNT_W-1:0]        size_s2;
	logic                    s2_done;

	logic [CNT_W-1:0]        queue_limit_q;
	logic [PW-1:0]           free_head_q;
	logic [FCW-1:0]          free_count_q;

	logic                    out_valid_q;
	spmq_pkg::status_t       out_status_q;
	logic [DATA_W-1:0]       out_data_q;
	logic [CNT_W-1:0]        out_count_q;

	logic [PW-1:0]           qt_head;
	logic [PW-1:0]           qt_tail;
	logic [CNT_W-1:0]        qt_size;
	logic [DATA_W-1:0]       sl_data;
	logic [PW-1:0]           sl_next;

	logic [CNT_W-1:0]        lim;
	spmq_pkg::status_t       st;
	logic [DATA_W-1:0]       dout;
	logic [PW-1:0]           n_head;
	logic [PW-1:0]           n_tail;
	logic [CNT_W-1:0]        n_size;
	logic                    qt_we;
	logic [PW-1:0]           fh_nxt;
	logic [FCW-1:0]          fc_nxt;
	logic                    take;
	logic                    sd_we;
	logic                    sn_we;
	logic [PW-1:0]           sn_addr;
	logic [PW-1:0]           sn_data;

	assign func_in = spmq_pkg::func_t'(s_axis_tdata[FUNC_W-1:0]);
	assign q_in    = qmap[s_axis_tdata[FUNC_W +: QID_W]];

	assign s2_done       = valid_s2 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 && (!valid_s2 || s2_done);
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_beat;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			func_s1    <= func_in;
			q_s1       <= q_in;
			payload_s1 <= s_axis_tdata[FUNC_W + QID_W +: DATA_W];
		end
		if (valid_s1) begin
			func_s2    <= func_s1;
			q_s2       <= q_s1;
			payload_s2 <= payload_s1;
			head_s2    <= qt_head;
			tail_s2    <= qt_tail;
			size_s2    <= qt_size;
		end
	end

	spmq_qtable #(
		.NUM_QUEUES (NUM_QUEUES),
		.PW         (PW)
	) u_qtable (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_beat),
		.rd_idx  (q_in),
		.rd_head (qt_head),
		.rd_tail (qt_tail),
		.rd_size (qt_size),
		.wr_en   (s2_done && qt_we),
		.wr_idx  (q_s2),
		.wr_head (n_head),
		.wr_tail (n_tail),
		.wr_size (n_size)
	);

	spmq_slots #(
		.POOL_DEPTH (POOL_DEPTH),
		.PW         (PW)
	) u_slots (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_en        (valid_s1),
		.rd_data_addr (qt_head),
		.rd_next_addr ((func_s1 == spmq_pkg::FUNC_POP_HEAD) ? qt_head : free_head_q),
		.rd_data      (sl_data),
		.rd_next      (sl_next),
		.wr_data_en   (s2_done && sd_we),
		.wr_data_addr (free_head_q),
		.wr_data      (payload_s2),
		.wr_next_en   (s2_done && sn_we),
		.wr_next_addr (sn_addr),
		.wr_next      (sn_data),
		.take_en      (s2_done && take),
		.take_addr    (free_head_q)
	);

	always_comb begin
		lim     = (queue_limit_q > spmq_pkg::QUEUE_CAP) ? spmq_pkg::QUEUE_CAP : queue_limit_q;
		st      = spmq_pkg::STAT_OK;
		dout    = '0;
		n_head  = head_s2;
		n_tail  = tail_s2;
		n_size  = size_s2;
		qt_we   = 1'b0;
		fh_nxt  = free_head_q;
		fc_nxt  = free_count_q;
		take    = 1'b0;
		sd_we   = 1'b0;
		sn_we   = 1'b0;
		sn_addr = free_head_q;
		sn_data = head_s2;
		case (func_s2)
			spmq_pkg::FUNC_PUSH_TAIL, spmq_pkg::FUNC_PUSH_HEAD: begin
				if (size_s2 >= lim) begin
					st = spmq_pkg::STAT_LIMIT;
				end else if (free_count_q == '0) begin
					st = spmq_pkg::STAT_EXHAUSTED;
				end else begin
					take   = 1'b1;
					sd_we  = 1'b1;
					qt_we  = 1'b1;
					fh_nxt = sl_next;
					fc_nxt = free_count_q - 1'b1;
					n_size = size_s2 + 1'b1;
					if (func_s2 == spmq_pkg::FUNC_PUSH_TAIL) begin
						if (size_s2 == '0) begin
							n_head = free_head_q;
						end else begin
							sn_we   = 1'b1;
							sn_addr = tail_s2;
							sn_data = free_head_q;
						end
						n_tail = free_head_q;
					end else begin
						sn_we   = 1'b1;
						sn_addr = free_head_q;
						sn_data = head_s2;
						if (size_s2 == '0) begin
							n_tail = free_head_q;
						end
						n_head = free_head_q;
					end
				end
			end
			spmq_pkg::FUNC_POP_HEAD: begin
				if (size_s2 == '0) begin
					st = spmq_pkg::STAT_EMPTY;
				end else begin
					dout    = sl_data;
					qt_we   = 1'b1;
					n_head  = sl_next;
					n_size  = size_s2 - 1'b1;
					sn_we   = 1'b1;
					sn_addr = head_s2;
					sn_data = free_head_q;
					fh_nxt  = head_s2;
					fc_nxt  = free_count_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_limit_q <= spmq_pkg::QUEUE_CAP;
			free_head_q   <= '0;
			free_count_q  <= FCW'(POOL_DEPTH);
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				queue_limit_q <= cfg_wdata;
			end
			if (s2_done) begin
				free_head_q  <= fh_nxt;
				free_count_q <= fc_nxt;
				out_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_done) begin
			out_status_q <= st;
			out_data_q   <= dout;
			out_count_q  <= n_size;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{spmq_pkg::OUT_PAD_W{1'b0}}, out_count_q, out_data_q, out_status_q};

	// at most one operation in the table/slot read path at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && valid_s2))
		else $error("s1 and s2 both occupied");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= FCW'(POOL_DEPTH))
		else $error("free count above pool depth");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_done && take) |=> (free_count_q == $past(free_count_q) - 1'b1))
		else $error("slot allocation did not shrink free count");

	a_pop_ok_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_done && (func_s2 == spmq_pkg::FUNC_POP_HEAD) && (size_s2 != '0))
		|=> (free_head_q == $past(head_s2)))
		else $error("popped slot not returned to free list head");

endmodule
